@@ sv/xtea_pkg.sv @@
package xtea_pkg;

  localparam int unsigned MaxRoundsDefault = 64;
  localparam int unsigned WordW            = 32;
  localparam int unsigned KeyShift         = 11;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned RoundCntW        = 7;

  localparam logic [WordW-1:0]     Delta         = 32'h9E37_79B9;
  localparam logic [RoundCntW-1:0] RoundCntReset = 7'd32;
  localparam logic                 CmdDecrypt    = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } cfg_reg_e;

  typedef logic [3:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             command;
    logic [WordW-1:0] first_word;
    logic [WordW-1:0] second_word;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] result_first;
    logic [WordW-1:0] result_second;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic             decrypt;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] sum;
  } stage_t;

  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

@@ sv/xtea_cell.sv @@
module xtea_cell import xtea_pkg::*; #(
  parameter int unsigned MaxRounds = MaxRoundsDefault,
  parameter int unsigned Index     = 0,
  localparam int unsigned RndW     = $clog2(MaxRounds + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  key_t            key_i,
  input  logic [RndW-1:0] n_i,
  input  stage_t          stage_i,
  output stage_t          stage_o
);

  localparam int unsigned RoundIdx = Index / 2;
  localparam bit          Even     = (Index % 2) == 0;

  logic             upd_v0;
  logic             active;
  logic [1:0]       sel;
  logic [WordW-1:0] x;
  logic [WordW-1:0] other;
  logic [WordW-1:0] t;
  logic [WordW-1:0] x_new;
  stage_t           stage_d;
  stage_t           data_q;
  logic             valid_q;

  // even cells: first half-round of a round, sum steps afterwards
  always_comb begin
    upd_v0  = Even ^ stage_i.decrypt;
    x       = upd_v0 ? stage_i.v0 : stage_i.v1;
    other   = upd_v0 ? stage_i.v1 : stage_i.v0;
    sel     = upd_v0 ? stage_i.sum[1:0] : stage_i.sum[KeyShift+1:KeyShift];
    t       = mix(other) ^ (stage_i.sum + key_i[sel]);
    x_new   = stage_i.decrypt ? (x - t) : (x + t);
    active  = n_i > RndW'(RoundIdx);
    stage_d = stage_i;
    if (active) begin
      if (upd_v0) begin
        stage_d.v0 = x_new;
      end else begin
        stage_d.v1 = x_new;
      end
    end
    if (Even) begin
      stage_d.sum = stage_i.decrypt ? (stage_i.sum - Delta) : (stage_i.sum + Delta);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= stage_d;
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

@@ sv/xtea_block_cipher_core.sv @@
// XTEA block cipher core, one fully unrolled half-round per pipeline cell.
//
// Input: item_i is taken on a rising edge with start_i high and busy_o low.
// busy_o stays low, so a new block may be started in every cycle.
// command 0 encrypts, 1 decrypts, using the configured key and round count.
//
// Output: result_o is valid for exactly one cycle while result_valid_o is
// high. The receiver cannot stall; results leave in input order.
//
// Pipeline: an entry register plus one register per half-round cell; the path
// through it does not depend on the configured round count.
// Throughput: one block per cycle, set by the chain of half-round cells.
//
// Config: cfg_index_i selects key word 0..3 or the round count (index 4),
// cfg_ready_o is always high. Counts above MaxRounds saturate. Write only
// while no block is in flight. Reset clears the key, sets 32 rounds and
// empties the pipeline.
module xtea_block_cipher_core import xtea_pkg::*; #(
  parameter int unsigned MaxRounds = MaxRoundsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  in_t                item_i,
  output logic               result_valid_o,
  output out_t               result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  localparam int unsigned NumCells = 2 * MaxRounds;
  localparam int unsigned Latency  = NumCells + 1;
  localparam int unsigned RndW     = $clog2(MaxRounds + 1);

  key_t                 key_q;
  logic [RoundCntW-1:0] rounds_q;
  logic [RndW-1:0]      n_eff;
  logic                 accept;
  logic                 entry_valid_q;
  stage_t               entry_d;
  stage_t               entry_q;
  stage_t               chain [NumCells+1];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rounds_q <= RoundCntReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY0:   key_q[0] <= cfg_data_i;
        REG_KEY1:   key_q[1] <= cfg_data_i;
        REG_KEY2:   key_q[2] <= cfg_data_i;
        REG_KEY3:   key_q[3] <= cfg_data_i;
        REG_ROUNDS: rounds_q <= cfg_data_i[RoundCntW-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (int'(rounds_q) > int'(MaxRounds)) ? RndW'(MaxRounds) : RndW'(rounds_q);

  always_comb begin
    entry_d.valid   = accept;
    entry_d.decrypt = item_i.command == CmdDecrypt;
    entry_d.v0      = item_i.first_word;
    entry_d.v1      = item_i.second_word;
    entry_d.sum     = entry_d.decrypt ? (Delta * WordW'(n_eff)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else begin
      entry_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_comb begin
    chain[0]       = entry_q;
    chain[0].valid = entry_valid_q;
  end

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    xtea_cell #(
      .MaxRounds(MaxRounds),
      .Index    (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .n_i    (n_eff),
      .stage_i(chain[k]),
      .stage_o(chain[k+1])
    );
  end

  assign result_valid_o         = chain[NumCells].valid;
  assign result_o.result_first  = chain[NumCells].v0;
  assign result_o.result_second = chain[NumCells].v1;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == $past(start_i && !busy_o && rst_ni, Latency))
    else $error("result strobe does not match accepted blocks");

  a_rounds_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(n_eff) <= int'(MaxRounds))
    else $error("effective round count exceeds maximum");

  a_enc_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_q && !entry_q.decrypt |-> entry_q.sum == '0)
    else $error("encrypt block entered with nonzero sum");

endmodule

@@ test/xtea_block_cipher_core_tb.sv @@
module xtea_block_cipher_core_tb import xtea_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLatency = 2 * MaxRoundsDefault + 1;
  localparam int unsigned NumRegs     = REG_ROUNDS + 1;
  localparam int unsigned CycleLimit  = 1_000_000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  in_t                 item_i      = '0;
  logic                result_valid_o;
  out_t                result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [WordW-1:0]    cfg_data_i  = '0;

  logic [WordW-1:0]     key_sched [4];
  logic [RoundCntW-1:0] round_setting;
  out_t                 expected_blocks [$];
  out_t                 want_block;
  int unsigned          failures    = 0;
  int unsigned          cycle_count = 0;

  xtea_block_cipher_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] scramble_word(input logic [WordW-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic out_t xtea_transform(input in_t blk);
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] s;
    int unsigned      n;
    out_t             res;
    v0 = blk.first_word;
    v1 = blk.second_word;
    n  = (round_setting > MaxRoundsDefault) ? MaxRoundsDefault : round_setting;
    if (blk.command == CmdDecrypt) begin
      s = Delta * n;
      for (int unsigned r = 0; r < n; r++) begin
        v1 = v1 - (scramble_word(v0) ^ (s + key_sched[s[KeyShift+1:KeyShift]]));
        s  = s - Delta;
        v0 = v0 - (scramble_word(v1) ^ (s + key_sched[s[1:0]]));
      end
    end else begin
      s = '0;
      for (int unsigned r = 0; r < n; r++) begin
        v0 = v0 + (scramble_word(v1) ^ (s + key_sched[s[1:0]]));
        s  = s + Delta;
        v1 = v1 + (scramble_word(v0) ^ (s + key_sched[s[KeyShift+1:KeyShift]]));
      end
    end
    res.result_first  = v0;
    res.result_second = v1;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result: %h %h", result_o.result_first, result_o.result_second);
        failures++;
      end else begin
        want_block = expected_blocks.pop_front();
        if (result_o.result_first !== want_block.result_first) begin
          $error("result_first: expected %h, actual %h",
                 want_block.result_first, result_o.result_first);
          failures++;
        end
        if (result_o.result_second !== want_block.result_second) begin
          $error("result_second: expected %h, actual %h",
                 want_block.result_second, result_o.result_second);
          failures++;
        end
      end
    end
  end

  // Called just after a rising edge; leaves start_i high for a back-to-back transfer.
  task automatic send_block(input in_t blk);
    start_i <= 1'b1;
    item_i  <= blk;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_blocks.push_back(xtea_transform(blk));
  endtask

  task automatic idle_for(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_sched[idx[1:0]] = data;
      REG_ROUNDS: round_setting = data[RoundCntW-1:0];
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_cipher(input key_t key, input logic [RoundCntW-1:0] rounds);
    wait_drained();
    cfg_write(REG_KEY0, key[0], 1'b0);
    cfg_write(REG_KEY1, key[1], 1'b0);
    cfg_write(REG_KEY2, key[2], 1'b0);
    cfg_write(REG_KEY3, key[3], 1'b0);
    cfg_write(REG_ROUNDS, WordW'(rounds), 1'b1);
  endtask

  function automatic key_t random_key();
    key_t k;
    for (int i = 0; i < 4; i++) k[i] = $urandom;
    return k;
  endfunction

  function automatic logic [WordW-1:0] random_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t make_block(input logic cmd, input logic [WordW-1:0] w0,
                                     input logic [WordW-1:0] w1);
    in_t b;
    b.command     = cmd;
    b.first_word  = w0;
    b.second_word = w1;
    return b;
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 9))
      7, 8:    return $urandom_range(5, 30);
      9:       return $urandom_range(31, PipeLatency + 60);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic test_reset_state();
    send_block(make_block(1'b0, '0, '0));
    send_block(make_block(CmdDecrypt, '1, '1));
    idle_for(3);
    send_block(make_block(1'b0, 32'h0123_4567, 32'h89AB_CDEF));
  endtask

  task automatic test_zero_rounds();
    set_cipher(random_key(), '0);
    send_block(make_block(1'b0, $urandom, $urandom));
    send_block(make_block(CmdDecrypt, '1, '0));
  endtask

  task automatic test_round_extremes();
    set_cipher(random_key(), RoundCntW'(1));
    send_block(make_block(1'b0, '0, '1));
    send_block(make_block(CmdDecrypt, $urandom, $urandom));
    set_cipher('1, RoundCntW'(MaxRoundsDefault));
    send_block(make_block(1'b0, '1, '1));
    send_block(make_block(CmdDecrypt, '0, '0));
    set_cipher('0, RoundCntW'(MaxRoundsDefault + 1));
    send_block(make_block(1'b0, $urandom, $urandom));
    set_cipher(random_key(), '1);
    send_block(make_block(1'b0, '1, '0));
    send_block(make_block(CmdDecrypt, $urandom, $urandom));
  endtask

  task automatic test_unused_index();
    wait_drained();
    for (int unsigned idx = NumRegs; idx < (1 << CfgIdxW); idx++)
      cfg_write(CfgIdxW'(idx), $urandom, idx == (1 << CfgIdxW) - 1);
    send_block(make_block(1'b0, $urandom, $urandom));
    send_block(make_block(CmdDecrypt, $urandom, $urandom));
  endtask

  task automatic stream_random_blocks(input int unsigned count, input bit pause_midway);
    int unsigned burst_left;
    burst_left = $urandom_range(1, 24);
    for (int unsigned k = 0; k < count; k++) begin
      send_block(make_block(1'($urandom_range(0, 1)), random_word(), random_word()));
      if (pause_midway && k == count / 2) begin
        wait_drained();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          idle_for(pick_gap());
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
        end
      end
    end
  endtask

  task automatic test_random_settings();
    logic [RoundCntW-1:0] rounds;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0:       rounds = '0;
        1:       rounds = RoundCntW'(1);
        2:       rounds = RoundCntW'(MaxRoundsDefault);
        3:       rounds = RoundCntW'($urandom_range(MaxRoundsDefault + 1, (1 << RoundCntW) - 1));
        default: rounds = RoundCntW'($urandom_range(2, MaxRoundsDefault - 1));
      endcase
      set_cipher(random_key(), rounds);
      stream_random_blocks(183, phase == 4);
    end
  endtask

  initial begin
    key_sched     = '{default: '0};
    round_setting = RoundCntReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_zero_rounds();
    test_round_extremes();
    test_unused_index();
    test_random_settings();
    wait_drained();
    repeat (PipeLatency + 8) @(posedge clk_i);
    if (expected_blocks.size() != 0) begin
      $error("%0d results never arrived", expected_blocks.size());
      failures++;
    end
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ xtea_block_cipher_core.f @@
sv/xtea_pkg.sv
sv/xtea_cell.sv
sv/xtea_block_cipher_core.sv
test/xtea_block_cipher_core_tb.sv
